// ===== src/rwtc_pkg.sv =====
package rwtc_pkg;

	// field widths
	localparam int LenW    = 16;
	localparam int FracW   = 16;
	localparam int TexW    = 11;
	localparam int RowW    = 11;
	localparam int ColW    = 11;
	localparam int ShW     = 12;
	localparam int TexOutW = 10;

	// divider: the quotient stays below the texture height, so TexW bits
	localparam int QuotW = TexW;
	localparam int NumW  = LenW + TexW;

	// top bits of the texel column product
	localparam int TxW = TexW + 1;

	// parameter defaults and reset value
	localparam int MAX_TEXTURE_SIZE_DEF = 1024;
	localparam int MAX_SCREEN_ROWS_DEF  = 2048;
	localparam logic [ShW-1:0] SCREEN_HEIGHT_RST = ShW'(1024);

	// payload carried through the divider stages
	typedef struct packed {
		logic               vis;
		logic [NumW-1:0]    rem;
		logic [QuotW-1:0]   quot;
		logic [LenW-1:0]    len;
		logic [TexOutW-1:0] tx;
		logic [ColW-1:0]    col;
		logic [RowW-1:0]    row;
	} div_t;

endpackage

// ===== src/rwtc_front.sv =====
module rwtc_front
	import rwtc_pkg::*;
#(
	parameter int MAX_TEXTURE_SIZE = MAX_TEXTURE_SIZE_DEF,
	parameter int MAX_SCREEN_ROWS  = MAX_SCREEN_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ShW-1:0]    screen_height,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [LenW-1:0]   wall_height,
	input  logic [FracW-1:0]  hit_fraction,
	input  logic              ray_positive,
	input  logic              side_is_y,
	input  logic [TexW-1:0]   texture_width,
	input  logic [TexW-1:0]   texture_height,
	input  logic [RowW-1:0]   screen_row,
	input  logic [ColW-1:0]   screen_column,
	output logic              out_valid,
	input  logic              out_ready,
	output div_t              out_data
);

	localparam logic [12:0] MaxTex  = 13'(MAX_TEXTURE_SIZE);
	localparam logic [12:0] MaxRows = 13'(MAX_SCREEN_ROWS);

	logic en1, en2;
	logic v_s1, v_s2;

	// stage 1 setup
	logic [TexW-1:0]    tw_l, th_l;
	logic [ShW-1:0]     h_l;
	logic signed [17:0] d, top, r, h_s, end_s;
	logic [FracW:0]     f;
	logic               vis;
	logic [LenW-1:0]    off;

	always_comb begin
		tw_l  = ({2'b0, texture_width} > MaxTex) ? MaxTex[TexW-1:0] : texture_width;
		th_l  = ({2'b0, texture_height} > MaxTex) ? MaxTex[TexW-1:0] : texture_height;
		h_l   = ({1'b0, screen_height} > MaxRows) ? MaxRows[ShW-1:0] : screen_height;
		h_s   = $signed({6'b0, h_l});
		d     = h_s - $signed({2'b0, wall_height});
		// halve, rounding toward zero
		top   = (d + $signed({17'b0, d[17]})) >>> 1;
		end_s = top + $signed({2'b0, wall_height});
		r     = $signed({7'b0, screen_row});
		vis   = (wall_height != '0) && (r >= top) && (r < end_s) && (r < h_s);
		off   = 16'(r - top);
		f     = (ray_positive == side_is_y) ? (17'h10000 - {1'b0, hit_fraction})
		                                    : {1'b0, hit_fraction};
	end

	logic               vis_s1;
	logic [LenW-1:0]    off_s1, len_s1;
	logic [TexW-1:0]    tw_s1, th_s1;
	logic [FracW:0]     f_s1;
	logic [ColW-1:0]    col_s1;
	logic [RowW-1:0]    row_s1;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			vis_s1 <= vis;
			off_s1 <= off;
			len_s1 <= wall_height;
			tw_s1  <= tw_l;
			th_s1  <= th_l;
			f_s1   <= f;
			col_s1 <= screen_column;
			row_s1 <= screen_row;
		end
	end

	// stage 2 multiplies
	logic [NumW-1:0]    num;
	logic [NumW:0]      pm;

	always_comb begin
		num = vis_s1 ? ({11'b0, off_s1} * {16'b0, th_s1}) : '0;
		pm  = {11'b0, f_s1} * {17'b0, tw_s1};
	end

	logic               vis_s2;
	logic [NumW-1:0]    num_s2;
	logic [TxW-1:0]     pm_s2;
	logic [LenW-1:0]    len_s2;
	logic [TexW-1:0]    tw_s2;
	logic [ColW-1:0]    col_s2;
	logic [RowW-1:0]    row_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			vis_s2 <= vis_s1;
			num_s2 <= num;
			pm_s2  <= pm[NumW:16];
			len_s2 <= len_s1;
			tw_s2  <= tw_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
		end
	end

	// clamp texel column to width-1
	logic [TexW-1:0] tx_c;

	always_comb begin
		if ((tw_s2 != '0) && (pm_s2 >= {1'b0, tw_s2})) begin
			tx_c = tw_s2 - TexW'(1);
		end else begin
			tx_c = pm_s2[TexW-1:0];
		end
		out_data.vis  = vis_s2;
		out_data.rem  = num_s2;
		out_data.quot = '0;
		out_data.len  = len_s2;
		out_data.tx   = tx_c[TexOutW-1:0];
		out_data.col  = col_s2;
		out_data.row  = row_s2;
	end

	assign out_valid = v_s2;

endmodule

// ===== src/rwtc_div_stage.sv =====
module rwtc_div_stage
	import rwtc_pkg::*;
#(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	logic            en;
	logic            v_s1;
	logic [NumW-1:0] dvs;
	div_t            nxt, d_s1;

	// one restoring step: try len shifted to this quotient bit
	always_comb begin
		dvs = NumW'(in_data.len) << BIT;
		nxt = in_data;
		if (in_data.rem >= dvs) begin
			nxt.rem       = in_data.rem - dvs;
			nxt.quot[BIT] = 1'b1;
		end
	end

	assign en       = !v_s1 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			d_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

endmodule

// ===== src/raycast_wall_texel_coordinate_top.sv =====
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_data (screen_height)
// in       in         in_valid / in_ready    wall_height .. screen_column
// out      out        out_valid / out_ready  visible, texel_column, texel_row, column_out, row_out
//
// one request per cycle sustained while out_ready stays high
// the pipeline is the setup and multiply stages plus one divider stage per quotient bit
// arst_n clears all stage valid bits and sets screen_height to 1024
// a stall on out_ready backs up stage by stage; bubbles are squeezed out
// in_ready follows out_ready combinationally once every stage holds a request
module raycast_wall_texel_coordinate_top
	import rwtc_pkg::*;
#(
	parameter int MAX_TEXTURE_SIZE = MAX_TEXTURE_SIZE_DEF,
	parameter int MAX_SCREEN_ROWS  = MAX_SCREEN_ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [ShW-1:0]     cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [LenW-1:0]    wall_height,
	input  logic [FracW-1:0]   hit_fraction,
	input  logic               ray_positive,
	input  logic               side_is_y,
	input  logic [TexW-1:0]    texture_width,
	input  logic [TexW-1:0]    texture_height,
	input  logic [RowW-1:0]    screen_row,
	input  logic [ColW-1:0]    screen_column,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               visible,
	output logic [TexOutW-1:0] texel_column,
	output logic [TexOutW-1:0] texel_row,
	output logic [ColW-1:0]    column_out,
	output logic [RowW-1:0]    row_out
);

	// screen height register, always writable
	logic [ShW-1:0] screen_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			screen_height_q <= cfg_data;
		end
	end

	// stage chain: index 0 is the front end output, QuotW the last divider stage
	logic chain_valid [QuotW+1];
	logic chain_ready [QuotW+1];
	div_t chain_data  [QuotW+1];

	// setup, slice bounds, both multiplies
	rwtc_front #(
		.MAX_TEXTURE_SIZE (MAX_TEXTURE_SIZE),
		.MAX_SCREEN_ROWS  (MAX_SCREEN_ROWS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.screen_height  (screen_height_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.wall_height    (wall_height),
		.hit_fraction   (hit_fraction),
		.ray_positive   (ray_positive),
		.side_is_y      (side_is_y),
		.texture_width  (texture_width),
		.texture_height (texture_height),
		.screen_row     (screen_row),
		.screen_column  (screen_column),
		.out_valid      (chain_valid[0]),
		.out_ready      (chain_ready[0]),
		.out_data       (chain_data[0])
	);

	// texel row divide, most significant quotient bit first
	for (genvar k = 0; k < QuotW; k++) begin : g_div
		rwtc_div_stage #(
			.BIT (QuotW - 1 - k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_data   (chain_data[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_data  (chain_data[k+1])
		);
	end

	// last divider stage is the output register
	div_t res;

	assign res                = chain_data[QuotW];
	assign chain_ready[QuotW] = out_ready;
	assign out_valid          = chain_valid[QuotW];
	assign visible            = res.vis;
	assign texel_column       = res.tx;
	// quotient is below texture height on a visible row, so no clamp is needed
	assign texel_row          = res.vis ? res.quot[TexOutW-1:0] : '0;
	assign column_out         = res.col;
	assign row_out            = res.row;

	// divide finished with a remainder below the divisor
	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res.vis |-> res.rem < {11'b0, res.len})
		else $error("divider remainder not below slice height");

	// hidden rows carry a zero numerator through the divider; a zero divisor sets every bit
	a_hidden_zero_quot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !res.vis && (res.len != '0) |-> res.quot == '0)
		else $error("hidden row produced a nonzero quotient");

	// back pressure only when the output holds a stalled request
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	// a visible row needs a nonzero slice height
	a_vis_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res.vis |-> res.len != '0)
		else $error("visible row with zero slice height");

endmodule

// ===== test/raycast_wall_texel_coordinate_top_test.sv =====
module raycast_wall_texel_coordinate_top_test;
	import rwtc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// one pixel query as it goes into the block
	typedef struct packed {
		logic [LenW-1:0]  wall_height;
		logic [FracW-1:0] hit_fraction;
		logic             ray_positive;
		logic             side_is_y;
		logic [TexW-1:0]  texture_width;
		logic [TexW-1:0]  texture_height;
		logic [RowW-1:0]  screen_row;
		logic [ColW-1:0]  screen_column;
	} query_t;

	// one texel result as it comes out
	typedef struct packed {
		logic               visible;
		logic [TexOutW-1:0] texel_column;
		logic [TexOutW-1:0] texel_row;
		logic [ColW-1:0]    column_out;
		logic [RowW-1:0]    row_out;
	} texel_t;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               cfg_valid      = 1'b0;
	logic               cfg_ready;
	logic [ShW-1:0]     cfg_data       = '0;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic [LenW-1:0]    wall_height    = '0;
	logic [FracW-1:0]   hit_fraction   = '0;
	logic               ray_positive   = 1'b0;
	logic               side_is_y      = 1'b0;
	logic [TexW-1:0]    texture_width  = '0;
	logic [TexW-1:0]    texture_height = '0;
	logic [RowW-1:0]    screen_row     = '0;
	logic [ColW-1:0]    screen_column  = '0;
	logic               out_valid;
	logic               out_ready      = 1'b0;
	logic               visible;
	logic [TexOutW-1:0] texel_column;
	logic [TexOutW-1:0] texel_row;
	logic [ColW-1:0]    column_out;
	logic [RowW-1:0]    row_out;

	// our copy of the screen height register
	logic [ShW-1:0] screen_rows_setting = SCREEN_HEIGHT_RST;

	// texels predicted for accepted queries, oldest first
	texel_t pending_texels[$];
	texel_t texel_due;
	int     failures = 0;

	// sender burst shaping
	bit sender_gaps = 1'b1;
	int burst_left  = 0;

	// receiver stall pattern and the long hold-off counter
	int stall_tick      = 0;
	int stall_mode      = 0;
	int hold_off_cycles = 0;

	raycast_wall_texel_coordinate_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.wall_height    (wall_height),
		.hit_fraction   (hit_fraction),
		.ray_positive   (ray_positive),
		.side_is_y      (side_is_y),
		.texture_width  (texture_width),
		.texture_height (texture_height),
		.screen_row     (screen_row),
		.screen_column  (screen_column),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.visible        (visible),
		.texel_column   (texel_column),
		.texel_row      (texel_row),
		.column_out     (column_out),
		.row_out        (row_out)
	);

	always #6 clk = ~clk;

	// hard stop in case the pipeline hangs
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// texel coordinates for one query under a given screen height
	function automatic texel_t texel_of(input query_t q, input logic [ShW-1:0] rows);
		longint h, len, tw, th, top, row_lo, row_hi, row, f, tx, ty;
		texel_t t;
		h   = (rows > MAX_SCREEN_ROWS_DEF) ? MAX_SCREEN_ROWS_DEF : rows;
		len = q.wall_height;
		tw  = (q.texture_width > MAX_TEXTURE_SIZE_DEF) ? MAX_TEXTURE_SIZE_DEF : q.texture_width;
		th  = (q.texture_height > MAX_TEXTURE_SIZE_DEF) ? MAX_TEXTURE_SIZE_DEF : q.texture_height;
		// centred slice, top truncated toward zero, may go negative
		top    = (h - len) / 2;
		row_lo = (top < 0) ? 0 : top;
		row_hi = top + len;
		if (row_hi > h)
			row_hi = h;
		row = q.screen_row;
		t.visible = (len != 0) && (row >= row_lo) && (row < row_hi);
		// flipped fraction on matching direction and side, zero becomes one
		if (q.ray_positive == q.side_is_y)
			f = 65536 - longint'(q.hit_fraction);
		else
			f = q.hit_fraction;
		tx = (f * tw) >> 16;
		if (tw == 0)
			tx = 0;
		else if (tx >= tw)
			tx = tw - 1;
		ty = 0;
		if (t.visible) begin
			ty = ((row - top) * th) / len;
			if (th == 0)
				ty = 0;
			else if (ty >= th)
				ty = th - 1;
		end
		t.texel_column = tx[TexOutW-1:0];
		t.texel_row    = ty[TexOutW-1:0];
		t.column_out   = q.screen_column;
		t.row_out      = q.screen_row;
		return t;
	endfunction

	// receiver: randomly picked stall pattern, long hold-off overrides it
	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			out_ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 2) != 0);
				2: out_ready <= (stall_tick % 4 == 0);
				default: out_ready <= ((stall_tick / 8) % 2 == 0);
			endcase
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// every accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_texels.size() == 0) begin
				$error("texel result with no request waiting: row %0d column %0d",
					row_out, column_out);
				failures++;
			end else begin
				texel_due = pending_texels.pop_front();
				check_field("visible", texel_due.visible, visible);
				check_field("texel_column", texel_due.texel_column, texel_column);
				check_field("texel_row", texel_due.texel_row, texel_row);
				check_field("column_out", texel_due.column_out, column_out);
				check_field("row_out", texel_due.row_out, row_out);
			end
		end
	end

	// offer one request, hold it until taken, then maybe pause
	task automatic send_query(input query_t q);
		int gap;
		@(negedge clk);
		in_valid       <= 1'b1;
		wall_height    <= q.wall_height;
		hit_fraction   <= q.hit_fraction;
		ray_positive   <= q.ray_positive;
		side_is_y      <= q.side_is_y;
		texture_width  <= q.texture_width;
		texture_height <= q.texture_height;
		screen_row     <= q.screen_row;
		screen_column  <= q.screen_column;
		do
			@(posedge clk);
		while (!in_ready);
		pending_texels.push_back(texel_of(q, screen_rows_setting));
		if (sender_gaps) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 24);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_fields(input int len, input int frac, input bit rpos, input bit sidey,
		input int tw, input int th, input int row, input int col);
		query_t q;
		q.wall_height    = LenW'(len);
		q.hit_fraction   = FracW'(frac);
		q.ray_positive   = rpos;
		q.side_is_y      = sidey;
		q.texture_width  = TexW'(tw);
		q.texture_height = TexW'(th);
		q.screen_row     = RowW'(row);
		q.screen_column  = ColW'(col);
		send_query(q);
	endtask

	// drop valid and let every predicted texel come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_texels.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_screen_height(input logic [ShW-1:0] rows);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= rows;
		do
			@(posedge clk);
		while (!cfg_ready);
		screen_rows_setting = rows;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random query, mostly slices that fit and rows on the screen
	function automatic query_t random_query(input logic [ShW-1:0] rows);
		query_t q;
		int h;
		h = (rows > MAX_SCREEN_ROWS_DEF) ? MAX_SCREEN_ROWS_DEF : rows;
		if (h == 0)
			h = 1;
		case ($urandom_range(0, 9))
			0: q.wall_height = LenW'($urandom_range(0, 65535));
			1: q.wall_height = LenW'($urandom_range(h, 4 * h));
			2: q.wall_height = LenW'($urandom_range(0, 2));
			default: q.wall_height = LenW'($urandom_range(1, h));
		endcase
		q.hit_fraction = FracW'($urandom_range(0, 65535));
		q.ray_positive = 1'($urandom_range(0, 1));
		q.side_is_y    = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0: q.texture_width = TexW'($urandom_range(0, 2047));
			1: q.texture_width = TexW'(1 << $urandom_range(0, 10));
			default: q.texture_width = TexW'($urandom_range(1, 1024));
		endcase
		case ($urandom_range(0, 7))
			0: q.texture_height = TexW'($urandom_range(0, 2047));
			1: q.texture_height = TexW'(1 << $urandom_range(0, 10));
			default: q.texture_height = TexW'($urandom_range(1, 1024));
		endcase
		if ($urandom_range(0, 9) < 3)
			q.screen_row = RowW'($urandom_range(0, 2047));
		else
			q.screen_row = RowW'($urandom_range(0, h - 1));
		q.screen_column = ColW'($urandom_range(0, 2047));
		return q;
	endfunction

	// slice edges, fraction flips and texture sizes at the reset height of 1024
	task automatic test_directed_slices();
		send_fields(0, 1234, 1, 0, 64, 64, 512, 0);          // empty slice
		send_fields(1, 32768, 1, 0, 64, 64, 511, 1);         // one-row slice, its only row
		send_fields(1, 32768, 1, 0, 64, 64, 512, 2);         // just below it
		send_fields(2, 100, 0, 1, 64, 64, 511, 3);
		send_fields(2, 100, 0, 1, 64, 64, 512, 4);           // second row of a two-row slice
		send_fields(1024, 0, 1, 0, 256, 256, 0, 5);          // slice fills the screen
		send_fields(1024, 65535, 0, 1, 256, 256, 1023, 6);
		send_fields(1025, 40000, 0, 0, 32, 32, 0, 7);        // odd overhang, top truncates to 0
		send_fields(65535, 5, 1, 1, 1024, 1024, 0, 8);       // slice far taller than the screen
		send_fields(65535, 5, 1, 1, 1024, 1024, 1023, 9);
		send_fields(65535, 5, 1, 1, 1024, 1024, 1024, 10);   // row below the screen
		send_fields(65535, 5, 1, 1, 1024, 1024, 2047, 11);
		// zero fraction, flipped to one (clamps to the last column) or not, and a near-one fraction
		send_fields(300, 0, 1, 1, 1024, 64, 512, 12);
		send_fields(300, 0, 0, 0, 16, 64, 512, 13);
		send_fields(300, 0, 1, 0, 16, 64, 512, 14);
		send_fields(300, 65535, 0, 1, 1024, 64, 512, 15);
		// zero, single and oversized textures
		send_fields(300, 30000, 1, 0, 0, 0, 512, 16);
		send_fields(300, 30000, 1, 0, 1, 1, 600, 17);
		send_fields(300, 65535, 0, 1, 1025, 1025, 661, 18);
		send_fields(300, 65535, 0, 1, 2047, 2047, 373, 2046);
		send_fields(1, 65535, 1, 0, 2047, 2047, 511, 2047);
	endtask

	// register extremes: tiny, full, zero, beyond the row limit
	task automatic test_screen_height_extremes();
		logic [ShW-1:0] heights[7];
		int h;
		int lens[5];
		heights = '{12'd1, 12'd2048, 12'd0, 12'd4095, 12'd2049, 12'd1023, 12'd3};
		foreach (heights[i]) begin
			set_screen_height(heights[i]);
			h = (heights[i] > MAX_SCREEN_ROWS_DEF) ? MAX_SCREEN_ROWS_DEF : heights[i];
			lens = '{0, 1, h, h + 1, 65535};
			foreach (lens[j]) begin
				send_fields(lens[j], $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 64, 128, 0, j);
				send_fields(lens[j], $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1024, 7, h / 2, j);
				send_fields(lens[j], $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 5, 1024, (h == 0) ? 0 : h - 1, j);
			end
			repeat (4) send_query(random_query(heights[i]));
		end
	endtask

	// bulk random queries across several screen heights
	task automatic test_random_queries();
		logic [ShW-1:0] rows;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: rows = SCREEN_HEIGHT_RST;
				3: rows = ShW'($urandom_range(2049, 4095));
				5: rows = ShW'($urandom_range(1, 64));
				default: rows = ShW'($urandom_range(1, 2048));
			endcase
			set_screen_height(rows);
			// one phase runs back to back with no sender gaps
			sender_gaps = (p != 2);
			repeat (140) send_query(random_query(screen_rows_setting));
		end
		sender_gaps = 1'b1;
	endtask

	// receiver holds off long enough for the pipeline to fill and stall input
	task automatic test_output_stall();
		wait_idle();
		sender_gaps     = 1'b0;
		hold_off_cycles = 300;
		repeat (80) send_query(random_query(screen_rows_setting));
		sender_gaps = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_slices();
		test_screen_height_extremes();
		test_random_queries();
		test_output_stall();

		// drain, then watch a while for stray results
		wait_idle();
		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rwtc_pkg.sv
src/rwtc_front.sv
src/rwtc_div_stage.sv
src/raycast_wall_texel_coordinate_top.sv
test/raycast_wall_texel_coordinate_top_test.sv
